### hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational accumulator unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int Width = 32;
  localparam int WideW = 2 * Width + 1;
  localparam int MagW  = 2 * Width;
  localparam int CntW  = $clog2(MagW + 1);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_MUL  = 2'd2,
    ACT_DIV  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_OVFL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_PREP,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul1;
    logic mul2;
    logic prep;
    logic gcd_step;
    logic divn_start;
    logic divd_start;
    logic div_step;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic zero_err;
    logic gcd_done;
    logic div_done;
    logic num_zero;
  } sts_t;

endpackage

### hdl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [31:0]       operand_num;
  logic signed [31:0]       operand_den;
  modport source (output valid, action, operand_num, operand_den, input ready);
  modport sink   (input valid, action, operand_num, operand_den, output ready);
endinterface

interface rau_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       result_num;
  logic [30:0]              result_den;
  logic [1:0]               status;
  modport source (output valid, result_num, result_den, status, input ready);
  modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

### hdl/rational_accumulator_unit_core.sv
// ----------------------------------------------------------------------------
// rational_accumulator_unit_core
// Reduced-fraction accumulator with load, add, multiply and divide.
// ----------------------------------------------------------------------------
// One word is processed at a time. The work per word is set by the binary
// GCD loop over the 64-bit magnitudes and two restoring divisions by the GCD.
// Divide-by-zero words skip the multiply, the GCD and the divisions, and words
// whose result numerator is zero skip the GCD and the divisions. The result
// word is held until taken.
module rational_accumulator_unit_core (
  input  logic       clk,
  input  logic       rst,
  rau_in_if.sink     in_ch,
  rau_out_if.source  out_ch
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rau_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (in_ch.action),
    .operand_num (in_ch.operand_num),
    .operand_den (in_ch.operand_den),
    .result_num  (out_ch.result_num),
    .result_den  (out_ch.result_den),
    .status      (out_ch.status)
  );

endmodule

### hdl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Accumulator, cross products, binary GCD and restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::cmd_t        cmd,
  output rau_pkg::sts_t        sts,
  input  logic [1:0]           action,
  input  logic signed [31:0]   operand_num,
  input  logic signed [31:0]   operand_den,
  output logic signed [31:0]   result_num,
  output logic [30:0]          result_den,
  output logic [1:0]           status
);

  localparam int MW = rau_pkg::MagW;
  localparam int CW = rau_pkg::CntW;

  logic signed [31:0] acc_num;
  logic signed [31:0] acc_den;
  logic [1:0]         act;
  logic signed [31:0] opn;
  logic signed [31:0] opd;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [63:0] p3;
  logic signed [64:0] wnum;
  logic signed [64:0] wden;
  logic               neg;
  logic [MW-1:0]      mn;
  logic [MW-1:0]      md;
  logic [MW-1:0]      ga;
  logic [MW-1:0]      gb;
  logic [CW-1:0]      shf;
  logic [MW-1:0]      dvd;
  logic [MW-1:0]      quo;
  logic [MW:0]        rem;
  logic [CW-1:0]      dcnt;
  logic [1:0]         stat;
  logic [MW:0]        trial;
  logic [MW-1:0]      g;
  logic [MW-1:0]      gdiff;
  logic [MW:0]        lim;
  logic               div_fin;
  logic               ovfl;

  assign g     = ga << shf;
  assign trial = {rem[MW-1:0], dvd[MW-1]} - {1'b0, g};
  assign gdiff = (ga > gb) ? ga - gb : gb - ga;
  assign lim   = (MW + 1)'(1) << (rau_pkg::Width - 1);
  assign ovfl  = (mn != '0) && ({1'b0, md} > lim - 1'b1 ||
                 (neg ? {1'b0, mn} > lim : {1'b0, mn} > lim - 1'b1));

  assign sts.zero_err = (opd == 0) || (act == rau_pkg::ACT_DIV && opn == 0);
  assign sts.gcd_done = (gb == '0);
  assign sts.div_done = (dcnt == '0);
  assign sts.num_zero = (mn == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= 32'sd1;
    end else if (cmd.check && !ovfl) begin
      acc_num <= neg ? -32'(mn) : 32'(mn);
      acc_den <= (mn == '0) ? 32'sd1 : 32'(md);
    end
    if (cmd.load_in) begin
      act <= action;
      opn <= operand_num;
      opd <= operand_den;
    end
    if (cmd.mul1) begin
      unique case (rau_pkg::action_t'(act))
        rau_pkg::ACT_LOAD: begin p1 <= 64'(opn); p2 <= 64'(opd); end
        rau_pkg::ACT_ADD:  begin
          p1 <= acc_num * opd;
          p2 <= opn * acc_den;
          p3 <= acc_den * opd;
        end
        rau_pkg::ACT_MUL:  begin p1 <= acc_num * opn; p2 <= acc_den * opd; end
        default:           begin p1 <= acc_num * opd; p2 <= acc_den * opn; end
      endcase
    end
    if (cmd.mul2) begin
      unique case (rau_pkg::action_t'(act))
        rau_pkg::ACT_ADD: begin
          wnum <= 65'(p1) + 65'(p2);
          wden <= 65'(p3);
        end
        default: begin
          wnum <= 65'(p1);
          wden <= 65'(p2);
        end
      endcase
    end
    if (cmd.prep) begin
      neg <= wnum[64] ^ wden[64];
      mn  <= MW'(wnum[64] ? -wnum : wnum);
      md  <= MW'(wden[64] ? -wden : wden);
      ga  <= MW'(wnum[64] ? -wnum : wnum);
      gb  <= MW'(wden[64] ? -wden : wden);
      shf <= '0;
    end
    if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1; gb <= gb >> 1; shf <= shf + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else begin
        ga <= (ga < gb) ? ga : gb;
        gb <= gdiff >> 1;
      end
    end
    if (cmd.divn_start || cmd.divd_start) begin
      dvd  <= cmd.divn_start ? mn : md;
      rem  <= '0;
      quo  <= '0;
      dcnt <= CW'(MW);
    end
    if (cmd.div_step) begin
      dvd  <= dvd << 1;
      dcnt <= dcnt - 1'b1;
      if (!trial[MW]) begin
        rem <= trial;
        quo <= {quo[MW-2:0], 1'b1};
      end else begin
        rem <= {rem[MW-1:0], dvd[MW-1]};
        quo <= {quo[MW-2:0], 1'b0};
      end
    end
    if (cmd.divd_start) mn <= quo;
    if (div_fin && !cmd.divd_start && !cmd.check) md <= quo;
    if (cmd.check) begin
      stat <= ovfl ? rau_pkg::ST_OVFL : rau_pkg::ST_OK;
    end
    if (cmd.load_in) stat <= rau_pkg::ST_DIVZ;
  end

  always_ff @(posedge clk) begin
    if (rst) div_fin <= 1'b0;
    else div_fin <= cmd.div_step && dcnt == CW'(1) && !cmd.divn_start;
  end

  assign result_num = acc_num;
  assign result_den = acc_den[30:0];
  assign status     = stat;

endmodule

### hdl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for multiply, GCD, divide, range check and result hand-off.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rau_pkg::cmd_t  cmd,
  input  rau_pkg::sts_t  sts
);

  rau_pkg::state_t state, state_next;
  logic            second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rau_pkg::S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = rau_pkg::S_MUL1;
        end
      end
      rau_pkg::S_MUL1: begin
        if (sts.zero_err) begin
          state_next = rau_pkg::S_OUT;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = rau_pkg::S_MUL2;
        end
      end
      rau_pkg::S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = rau_pkg::S_PREP;
      end
      rau_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD: begin
        if (sts.num_zero) begin
          state_next = rau_pkg::S_CHECK;
        end else if (sts.gcd_done) begin
          cmd.divn_start = 1'b1;
          second_next    = 1'b0;
          state_next     = rau_pkg::S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      rau_pkg::S_DIVN: begin
        if (sts.div_done) begin
          if (!second) begin
            cmd.divd_start = 1'b1;
            second_next    = 1'b1;
          end else begin
            state_next = rau_pkg::S_DIVD;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::S_DIVD: begin
        state_next = rau_pkg::S_CHECK;
      end
      rau_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = rau_pkg::S_OUT;
      end
      rau_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = rau_pkg::S_IDLE;
      end
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

endmodule
